### rtl/frml_pkg.sv
// Shared constants and types for the frame rate meter and limiter.
`timescale 1ns / 1ps

package frml_pkg;

   // Sample window and field widths
   localparam int WINDOW      = 10;
   localparam int SAMPLE_W    = 16;
   localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W       = $clog2(WINDOW + 1);
   localparam int SUM_W       = SAMPLE_W + ((WINDOW > 1) ? $clog2(WINDOW) : 1);
   localparam int TIME_W      = 32;
   localparam int FPS_W       = 22;
   localparam int FPS_CFG_W   = 10;
   localparam int DELAY_W     = 10;

   // Rate numerator: 1000 ms per second scaled by 2^8
   localparam int RATE_Q8_NUM = 256000;
   localparam int NUM_RAW_W   = $clog2(RATE_Q8_NUM * WINDOW + 1);
   localparam int NUM_W       = (NUM_RAW_W > FPS_W) ? NUM_RAW_W : FPS_W;
   localparam int DEN_W       = (SUM_W > FPS_CFG_W) ? SUM_W : FPS_CFG_W;
   localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

   localparam int FPS_Q8_MAX     = 4194303;
   localparam int DEFAULT_FPS_Q8 = 15360;
   localparam int BUDGET_NUM     = 1000;
   localparam int MAX_FPS_RESET  = 60;
   localparam int FRAME_MS_MAX   = 65535;

   // Command codes
   localparam logic CMD_BEGIN = 1'b0;
   localparam logic CMD_END   = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

### rtl/frml_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module frml_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [frml_pkg::NUM_W-1:0]   dividend,
   input  logic [frml_pkg::DEN_W-1:0]   divisor,
   output frml_pkg::div_stat_type       stat,
   output logic [frml_pkg::NUM_W-1:0]   quotient
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [frml_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [frml_pkg::NUM_W-1:0]         quo_ff, quo_in;
   logic [frml_pkg::DEN_W-1:0]         rem_ff, rem_in;
   logic [frml_pkg::DEN_W-1:0]         den_ff, den_in;
   logic [frml_pkg::DEN_W:0]           trial;
   logic                               qbit;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[frml_pkg::NUM_W-1]};
      qbit    = (trial >= {1'b0, den_ff});
      if (busy_ff) begin
         // remainder stays below the divisor, so the difference fits
         rem_in = qbit ? frml_pkg::DEN_W'(trial - {1'b0, den_ff})
                       : trial[frml_pkg::DEN_W-1:0];
         quo_in = {quo_ff[frml_pkg::NUM_W-2:0], qbit};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == frml_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = frml_pkg::DIV_CNT_W'(frml_pkg::NUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

### rtl/frame_rate_meter_limiter.sv
// Top level: frame time ring, running sum, rate average and limiter delay.
`timescale 1ns / 1ps

//  channel | ports                                      | direction
//  req     | req_valid/ready, req_command, req_now_ms    | in
//  rsp     | rsp_valid/ready, rsp_fps_q8/frame_ms/delay  | out
//  csr     | csr_write_en, csr_write_data (max_fps)      | in
//
// A begin event only records its start time. An end event runs the bit-serial
// divider twice: average rate, then the frame budget 1000/max_fps. The sample
// ring is a one-port memory read at the accept edge and written back in the
// next cycle; one event is in flight at a time. Reset clears the control state;
// ring entries are never read before written. A result waiting on rsp_ready
// holds the output register only, and a begin event is still taken meanwhile.

module frame_rate_meter_limiter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_command,
   input  logic [31:0]                        req_now_ms,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [21:0]                        rsp_fps_q8,
   output logic [15:0]                        rsp_frame_ms,
   output logic [9:0]                         rsp_delay_ms,
   input  logic                               csr_write_en,
   input  logic [9:0]                         csr_write_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_UPD  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FPS  = 3'd3;
   localparam logic [2:0] ST_BUD  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]                          state_ff, state_in;
   logic [frml_pkg::FPS_CFG_W-1:0]      max_fps_ff;
   logic [frml_pkg::TIME_W-1:0]         frame_start_ff;
   logic [frml_pkg::TIME_W-1:0]         last_end_ff;
   logic                                primed_ff;
   logic [frml_pkg::SLOT_W-1:0]         slot_ff;
   logic [frml_pkg::CNT_W-1:0]          count_ff;
   logic [frml_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic                                rsp_valid_ff;

   logic [frml_pkg::SAMPLE_W-1:0]       delta_ff, delta_in;
   logic [frml_pkg::TIME_W-1:0]         elapsed_ff;
   logic [frml_pkg::FPS_W-1:0]          fps_ff;
   logic [frml_pkg::DELAY_W-1:0]        delay_ff;
   logic [frml_pkg::FPS_W-1:0]          out_fps_ff;
   logic [frml_pkg::SAMPLE_W-1:0]       out_frame_ff;
   logic [frml_pkg::DELAY_W-1:0]        out_delay_ff;

   logic [frml_pkg::SAMPLE_W-1:0]       ring_mem [frml_pkg::WINDOW];
   logic [frml_pkg::SAMPLE_W-1:0]       ring_rd_ff;

   logic                                req_xfer;
   logic                                end_xfer;
   logic                                begin_xfer;
   logic                                out_free;
   logic                                full;
   logic [frml_pkg::TIME_W-1:0]         diff;
   logic [frml_pkg::FPS_CFG_W-1:0]      target;
   logic                                div_start;
   logic [frml_pkg::NUM_W-1:0]          div_num;
   logic [frml_pkg::DEN_W-1:0]          div_den;
   frml_pkg::div_stat_type              div_stat;
   logic [frml_pkg::NUM_W-1:0]          div_quo;
   logic [frml_pkg::FPS_W-1:0]          fps_val;
   logic [frml_pkg::DELAY_W-1:0]        budget;
   logic [frml_pkg::DELAY_W-1:0]        delay_val;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_xfer   = req_valid && req_ready;
   assign end_xfer   = req_xfer && (req_command == frml_pkg::CMD_END);
   assign begin_xfer = req_xfer && (req_command == frml_pkg::CMD_BEGIN);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign full       = (count_ff >= frml_pkg::CNT_W'(frml_pkg::WINDOW));

   // Frame time since the previous end event (zero before the first), saturated to the sample width
   always_comb begin
      diff = req_now_ms - last_end_ff;
      if (!primed_ff) begin
         delta_in = '0;
      end else if (diff > frml_pkg::TIME_W'(frml_pkg::FRAME_MS_MAX)) begin
         delta_in = frml_pkg::SAMPLE_W'(frml_pkg::FRAME_MS_MAX);
      end else begin
         delta_in = diff[frml_pkg::SAMPLE_W-1:0];
      end
   end

   // Running sum: drop the oldest sample once the window is full
   always_comb begin
      sum_in = sum_ff + frml_pkg::SUM_W'(delta_ff);
      if (full) begin
         sum_in = sum_in - frml_pkg::SUM_W'(ring_rd_ff);
      end
   end

   assign target    = (max_fps_ff == '0) ? frml_pkg::FPS_CFG_W'(1) : max_fps_ff;
   assign div_start = (state_ff == ST_DIV) || ((state_ff == ST_FPS) && div_stat.done);
   assign div_num   = (state_ff == ST_DIV)
                      ? frml_pkg::NUM_W'(frml_pkg::RATE_Q8_NUM) *
                        frml_pkg::NUM_W'(count_ff)
                      : frml_pkg::NUM_W'(frml_pkg::BUDGET_NUM);
   assign div_den   = (state_ff == ST_DIV) ? frml_pkg::DEN_W'(sum_ff)
                                           : frml_pkg::DEN_W'(target);

   always_comb begin
      if (sum_ff == '0) begin
         fps_val = frml_pkg::FPS_W'(frml_pkg::DEFAULT_FPS_Q8);
      end else if (div_quo > frml_pkg::NUM_W'(frml_pkg::FPS_Q8_MAX)) begin
         fps_val = frml_pkg::FPS_W'(frml_pkg::FPS_Q8_MAX);
      end else begin
         fps_val = div_quo[frml_pkg::FPS_W-1:0];
      end
   end

   // Budget never exceeds 1000, so it fits the delay width
   assign budget    = div_quo[frml_pkg::DELAY_W-1:0];
   assign delay_val = (frml_pkg::TIME_W'(budget) > elapsed_ff)
                      ? budget - elapsed_ff[frml_pkg::DELAY_W-1:0] : '0;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (end_xfer) state_in = ST_UPD;
         ST_UPD:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_FPS;
         ST_FPS:  if (div_stat.done) state_in = ST_BUD;
         ST_BUD:  if (div_stat.done) state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   frml_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // Ring memory: read at the accept edge, written back in the update cycle.
   // Only one event is in flight, so read and write of a slot never overlap.
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPD) begin
         ring_mem[slot_ff] <= delta_ff;
      end
      ring_rd_ff <= ring_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         max_fps_ff     <= frml_pkg::FPS_CFG_W'(frml_pkg::MAX_FPS_RESET);
         frame_start_ff <= '0;
         last_end_ff    <= '0;
         primed_ff      <= 1'b0;
         slot_ff        <= '0;
         count_ff       <= '0;
         sum_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            max_fps_ff <= csr_write_data;
         end
         if (begin_xfer) begin
            frame_start_ff <= req_now_ms;
         end
         if (end_xfer) begin
            last_end_ff <= req_now_ms;
            primed_ff   <= 1'b1;
         end
         if (state_ff == ST_UPD) begin
            sum_ff  <= sum_in;
            slot_ff <= (slot_ff == frml_pkg::SLOT_W'(frml_pkg::WINDOW - 1))
                       ? '0 : slot_ff + 1'b1;
            if (!full) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (end_xfer) begin
         delta_ff   <= delta_in;
         elapsed_ff <= req_now_ms - frame_start_ff;
      end
      if ((state_ff == ST_FPS) && div_stat.done) begin
         fps_ff <= fps_val;
      end
      if ((state_ff == ST_BUD) && div_stat.done) begin
         delay_ff <= delay_val;
      end
      if ((state_ff == ST_OUT) && out_free) begin
         out_fps_ff   <= fps_ff;
         out_frame_ff <= delta_ff;
         out_delay_ff <= delay_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_fps_q8   = out_fps_ff;
   assign rsp_frame_ms = out_frame_ff;
   assign rsp_delay_ms = out_delay_ff;

endmodule

### rtl/frml_check.sv
// Port-level checks for the frame rate meter and limiter, bound to the top.
`timescale 1ns / 1ps

module frml_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [21:0] rsp_fps_q8,
   input logic [15:0] rsp_frame_ms,
   input logic [9:0]  rsp_delay_ms
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fps_q8) &&
      $stable(rsp_frame_ms) && $stable(rsp_delay_ms))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A begin transfer never produces a result
   a_begin_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_command && (!rsp_valid || rsp_ready)
      |=> !rsp_valid)
      else $error("result after begin transfer");

   // An end transfer needs the divider, so no result in the next cycle
   a_end_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command && (!rsp_valid || rsp_ready)
      |=> !rsp_valid)
      else $error("result too early after end transfer");

   a_delay_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_delay_ms <= 10'd1000)
      else $error("delay above 1000 ms");

endmodule

bind frame_rate_meter_limiter frml_check u_frml_check (.*);

### tb/testbench.sv
// Self-checking testbench for the frame rate meter and limiter.
`timescale 1ns / 1ps

module testbench;

   typedef struct packed {
      logic [frml_pkg::FPS_W-1:0]   fps_q8;
      logic [15:0]                  frame_ms;
      logic [frml_pkg::DELAY_W-1:0] delay_ms;
   } meter_reading_type;

   typedef struct packed {
      logic                         cmd;
      logic [31:0]                  now_ms;
      logic                         typed;
      logic [frml_pkg::FPS_W-1:0]   fps_q8;
      logic [15:0]                  frame_ms;
      logic [frml_pkg::DELAY_W-1:0] delay_ms;
   } stim_row_type;

   localparam int NUM_ROWS = 20;
   localparam int NUM_PHASES = 7;
   localparam int PHASE_ITEMS = 62;
   localparam int DRAIN_CYCLES = 60;
   localparam meter_reading_type NO_READING = '0;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_command = frml_pkg::CMD_BEGIN;
   logic [31:0]          req_now_ms = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [21:0]          rsp_fps_q8;
   logic [15:0]          rsp_frame_ms;
   logic [9:0]           rsp_delay_ms;
   logic                 csr_write_en = 1'b0;
   logic [9:0]           csr_write_data = '0;

   // predictor state
   logic [frml_pkg::FPS_CFG_W-1:0] target_fps =
      frml_pkg::FPS_CFG_W'(frml_pkg::MAX_FPS_RESET);
   logic [31:0]          frame_start_ms = '0;
   logic [31:0]          last_end_ms = '0;
   bit                   seen_end = 1'b0;
   logic [15:0]          frame_hist [frml_pkg::WINDOW];
   int unsigned          hist_slot = 0;
   longint unsigned      hist_count = 0;
   longint unsigned      hist_sum = 0;

   meter_reading_type    expected_readings [$];
   int                   error_count = 0;
   int                   items_sent = 0;
   int                   readings_checked = 0;
   int                   stall_request = 0;
   bit                   req_eager = 1'b0;
   bit                   rsp_eager = 1'b0;
   logic [31:0]          host_ms = '0;

   frame_rate_meter_limiter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_now_ms     (req_now_ms),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_fps_q8     (rsp_fps_q8),
      .rsp_frame_ms   (rsp_frame_ms),
      .rsp_delay_ms   (rsp_delay_ms),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      error_count++;
      if (error_count <= 30) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Advance the meter by one event; returns 1 when the event yields a reading.
   function automatic bit step_meter(input logic cmd, input logic [31:0] now,
                                     output meter_reading_type rd);
      logic [31:0]     gap_ms;
      logic [31:0]     elapsed;
      longint unsigned rate;
      int unsigned     budget;
      rd = '0;
      if (cmd == frml_pkg::CMD_BEGIN) begin
         frame_start_ms = now;
         return 1'b0;
      end
      gap_ms = seen_end ? now - last_end_ms : 32'd0;
      if (gap_ms > 32'(frml_pkg::FRAME_MS_MAX)) gap_ms = 32'(frml_pkg::FRAME_MS_MAX);
      last_end_ms = now;
      seen_end = 1'b1;
      if (hist_count >= frml_pkg::WINDOW) hist_sum -= frame_hist[hist_slot];
      else hist_count++;
      frame_hist[hist_slot] = gap_ms[15:0];
      hist_sum += gap_ms;
      hist_slot = (hist_slot + 1) % frml_pkg::WINDOW;
      if (hist_sum == 0) rate = frml_pkg::DEFAULT_FPS_Q8;
      else rate = (frml_pkg::RATE_Q8_NUM * hist_count) / hist_sum;
      if (rate > frml_pkg::FPS_Q8_MAX) rate = frml_pkg::FPS_Q8_MAX;
      budget = frml_pkg::BUDGET_NUM / ((target_fps == 0) ? 1 : target_fps);
      // full 32-bit wrapped elapsed time, no saturation
      elapsed = now - frame_start_ms;
      rd.fps_q8 = rate[21:0];
      rd.frame_ms = gap_ms[15:0];
      rd.delay_ms = (budget > elapsed) ? frml_pkg::DELAY_W'(budget - elapsed) : '0;
      return 1'b1;
   endfunction

   function automatic int idle_gap(input bit eager);
      int r;
      r = $urandom_range(0, 99);
      if (eager || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   function automatic logic [31:0] time_step();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(0, 40);
      if (r < 95) return $urandom_range(41, 2000);
      if (r < 98) return $urandom_range(65000, 200000);
      return $urandom();
   endfunction

   task automatic send_item(input logic cmd, input logic [31:0] now,
                            input bit use_typed, input meter_reading_type typed);
      meter_reading_type predicted;
      repeat (idle_gap(req_eager)) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_now_ms <= now;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (step_meter(cmd, now, predicted))
         expected_readings.push_back(use_typed ? typed : predicted);
   endtask

   // Drop valid, wait for all readings, then let an in-flight event finish.
   task automatic settle_block();
      int waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_readings.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input int quota);
      int sent;
      int r;
      int unsigned budget;
      sent = 0;
      while (sent < quota) begin
         r = $urandom_range(0, 99);
         budget = frml_pkg::BUDGET_NUM / ((target_fps == 0) ? 1 : target_fps);
         if (r < 75) begin
            // well-formed frame: begin, then end somewhere around the budget
            host_ms += time_step();
            send_item(frml_pkg::CMD_BEGIN, host_ms, 1'b0, NO_READING);
            host_ms += $urandom_range(0, budget + 4);
            send_item(frml_pkg::CMD_END, host_ms, 1'b0, NO_READING);
            sent += 2;
         end else if (r < 85) begin
            host_ms += time_step();
            send_item(frml_pkg::CMD_END, host_ms, 1'b0, NO_READING);
            sent++;
         end else if (r < 92) begin
            send_item(frml_pkg::CMD_BEGIN, host_ms + $urandom_range(0, 20), 1'b0,
                      NO_READING);
            sent++;
         end else begin
            send_item(1'($urandom_range(0, 1)), $urandom(), 1'b0, NO_READING);
            sent++;
         end
      end
   endtask

   // receiver: random back-pressure, plus one forced long hold
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (stall_request > 0) begin
            hold = stall_request;
            stall_request = 0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = idle_gap(rsp_eager);
         end
      end
   end

   initial begin
      meter_reading_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               flag_mismatch($sformatf("result with nothing pending: fps %0d frame %0d %s %0d",
                                       rsp_fps_q8, rsp_frame_ms, "delay", rsp_delay_ms));
            end else begin
               want = expected_readings.pop_front();
               readings_checked++;
               if (rsp_fps_q8 !== want.fps_q8)
                  flag_mismatch($sformatf("fps_q8 got %0d want %0d", rsp_fps_q8, want.fps_q8));
               if (rsp_frame_ms !== want.frame_ms)
                  flag_mismatch($sformatf("frame_ms got %0d want %0d",
                                          rsp_frame_ms, want.frame_ms));
               if (rsp_delay_ms !== want.delay_ms)
                  flag_mismatch($sformatf("delay_ms got %0d want %0d",
                                          rsp_delay_ms, want.delay_ms));
            end
         end
      end
   end

   initial begin
      stim_row_type opening_rows [NUM_ROWS];
      logic [frml_pkg::FPS_CFG_W-1:0] fps_plan [NUM_PHASES];
      opening_rows = '{
         // end with no begin and no prior end: zero frame time, default rate
         '{frml_pkg::CMD_END,   32'd0,         1'b1, 22'd15360, 16'd0,     10'd16},
         '{frml_pkg::CMD_END,   32'd0,         1'b1, 22'd15360, 16'd0,     10'd16},
         '{frml_pkg::CMD_BEGIN, 32'd100,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'd100,       1'b1, 22'd7680,  16'd100,   10'd16},
         // timestamp wraps between begin and end; frame time saturates
         '{frml_pkg::CMD_BEGIN, 32'hFFFF_FFF0, 1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'd5,         1'b1, 22'd15,    16'd65535, 10'd0},
         '{frml_pkg::CMD_BEGIN, 32'hFFFF_FFFF, 1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'hFFFF_FFFF, 1'b1, 22'd9,     16'd65535, 10'd16},
         // end before its begin: elapsed wraps to nearly 2^32
         '{frml_pkg::CMD_BEGIN, 32'd200,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'd199,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_BEGIN, 32'd210,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'd212,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'd228,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'd244,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'd260,       1'b0, 22'd0,     16'd0,     10'd0},
         // window full from here: oldest samples drop out
         '{frml_pkg::CMD_END,   32'd276,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'd292,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'd308,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_BEGIN, 32'd308,       1'b0, 22'd0,     16'd0,     10'd0},
         '{frml_pkg::CMD_END,   32'd308,       1'b0, 22'd0,     16'd0,     10'd0}
      };
      // all ones, zero target, slowest and fastest in range, then mixed
      fps_plan = '{10'd1023, 10'd0, 10'd1, 10'd1000,
                   10'($urandom_range(2, 999)), 10'd512, 10'd60};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (opening_rows[i])
         send_item(opening_rows[i].cmd, opening_rows[i].now_ms, opening_rows[i].typed,
                   {opening_rows[i].fps_q8, opening_rows[i].frame_ms,
                    opening_rows[i].delay_ms});
      host_ms = 32'd308;

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle_block();
         req_eager = (p == 3);
         rsp_eager = (p == 3);
         if (p == 1) stall_request = 300;
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_write_data <= fps_plan[p];
         @(negedge clock);
         csr_write_en <= 1'b0;
         target_fps = fps_plan[p];
         if (p == 5) host_ms = $urandom();
         run_phase(PHASE_ITEMS);
      end
      settle_block();

      while (expected_readings.size() != 0) begin
         void'(expected_readings.pop_front());
         flag_mismatch("expected reading never arrived");
      end

      $display("run covered %0d transfers in and %0d readings out over %0d target rates",
               items_sent, readings_checked, NUM_PHASES);
      $display("including wrapped and saturated timestamps and a long output stall");
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/frml_pkg.sv
rtl/frml_div.sv
rtl/frame_rate_meter_limiter.sv
rtl/frml_check.sv
tb/testbench.sv
